// ===== sv/per_channel_gain_mute_assert.svh =====
// ---------------------------------------------------------------------------
// per_channel_gain_mute assertion macros
// Concurrent check wrappers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PER_CHANNEL_GAIN_MUTE_ASSERT_SVH
`define PER_CHANNEL_GAIN_MUTE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define PCGM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PCGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PCGM_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PCGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/pcgm_pkg.sv =====
// ---------------------------------------------------------------------------
// pcgm_pkg
// Shared types and constants for the per-channel gain and mute block.
// ---------------------------------------------------------------------------
`default_nettype none

package pcgm_pkg;

  // frame and gain format
  localparam int MAX_CHANNELS   = 8;
  localparam int GAIN_FRAC_BITS = 15;
  localparam int GAIN_W         = 16;
  localparam int SAMPLE_W       = 32;
  localparam int POS_W          = 3;
  localparam int COUNT_W        = 4;
  localparam int PROD_W         = SAMPLE_W + GAIN_W;

  localparam logic [GAIN_W-1:0]  GAIN_UNITY  = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_CHANNELS);
  localparam logic [3:0]         MAP_NO_ENTRY_BIT = 4'd8;

  // register reset values
  localparam logic [63:0] GAINS_RESET      = 64'h8000_8000_8000_8000;
  localparam logic [7:0]  MUTE_RESET       = 8'h00;
  localparam logic [3:0]  CHAN_COUNT_RESET = 4'd2;
  localparam logic [31:0] CHAN_MAP_RESET   = 32'h7654_3210;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GAINS_LOW     = 3'd0,
    REG_GAINS_HIGH    = 3'd1,
    REG_MUTE_MASK     = 3'd2,
    REG_CHANNEL_COUNT = 3'd3,
    REG_SAMPLE_WIDTH  = 3'd4,
    REG_CHANNEL_MAP   = 3'd5
  } pcgm_reg_t;

  // sample width codes
  typedef enum logic [1:0] {
    WIDTH_16   = 2'd0,
    WIDTH_32   = 2'd1,
    WIDTH_RAW  = 2'd2,
    WIDTH_RAW3 = 2'd3
  } pcgm_width_t;

  // what the second stage does with an item
  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_ZERO  = 2'd1,
    OP_SCALE = 2'd2
  } pcgm_op_t;

  typedef struct packed {
    logic [63:0]  gains_low;
    logic [63:0]  gains_high;
    logic [7:0]   mute_mask;
    logic [3:0]   channel_count;
    pcgm_width_t  sample_width;
    logic [31:0]  channel_map;
  } pcgm_cfg_t;

  // decoded item between the two stages; value is the magnitude for scale
  typedef struct packed {
    pcgm_op_t              op;
    logic                  neg;
    logic                  narrow;
    logic [GAIN_W-1:0]     gain;
    logic [SAMPLE_W-1:0]   value;
  } pcgm_item_t;

endpackage

`default_nettype wire

// ===== sv/pcgm_regs.sv =====
// ---------------------------------------------------------------------------
// pcgm_regs
// Configuration register file, written through an indexed write channel.
// ---------------------------------------------------------------------------
`default_nettype none

module pcgm_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  output      pcgm_pkg::pcgm_cfg_t cfg
);
  import pcgm_pkg::*;

  // always able to take a write request
  assign cfg_ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gains_low     <= GAINS_RESET;
      cfg.gains_high    <= GAINS_RESET;
      cfg.mute_mask     <= MUTE_RESET;
      cfg.channel_count <= CHAN_COUNT_RESET;
      cfg.sample_width  <= WIDTH_16;
      cfg.channel_map   <= CHAN_MAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcgm_reg_t'(cfg_index))
        REG_GAINS_LOW:     cfg.gains_low     <= cfg_data;
        REG_GAINS_HIGH:    cfg.gains_high    <= cfg_data;
        REG_MUTE_MASK:     cfg.mute_mask     <= cfg_data[7:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[3:0];
        REG_SAMPLE_WIDTH:  cfg.sample_width  <= pcgm_width_t'(cfg_data[1:0]);
        REG_CHANNEL_MAP:   cfg.channel_map   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcgm_frame.sv =====
// ---------------------------------------------------------------------------
// pcgm_frame
// Frame position tracking, channel map and gain lookup, input register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "per_channel_gain_mute_assert.svh"

module pcgm_frame (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pcgm_pkg::pcgm_cfg_t  cfg,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [31:0]          in_sample,
  input  wire logic                 in_start,
  input  wire logic                 take,
  output      logic                 item_valid,
  output      pcgm_pkg::pcgm_item_t item
);
  import pcgm_pkg::*;

  logic [POS_W-1:0]    frame_position;
  logic [POS_W-1:0]    frame_position_next;
  logic [POS_W-1:0]    pos;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  pos_inc;
  logic                accept;
  logic [3:0]          entry;
  logic [2*64-1:0]     gain_table;
  logic [GAIN_W-1:0]   gain_raw;
  logic [SAMPLE_W-1:0] sample_ext;
  logic                neg;
  pcgm_item_t          item_next;

  assign in_ready = !item_valid || take;
  assign accept   = in_valid && in_ready;

  // position of this sample and the one after it
  assign count   = (cfg.channel_count > COUNT_MAX) ? COUNT_MAX : cfg.channel_count;
  assign pos     = in_start ? '0 : frame_position;
  assign pos_inc = {1'b0, pos} + COUNT_W'(1);

  always_comb begin
    if (count == '0) begin
      frame_position_next = pos;
    end else if (pos_inc >= count) begin
      frame_position_next = '0;
    end else begin
      frame_position_next = pos_inc[POS_W-1:0];
    end
  end

  // map lookup and gain select
  assign entry      = cfg.channel_map[{pos, 2'b00} +: 4];
  assign gain_table = {cfg.gains_high, cfg.gains_low};
  assign gain_raw   = gain_table[{entry[2:0], 4'b0000} +: GAIN_W];

  // sample as seen in the current width and its sign
  assign sample_ext = (cfg.sample_width == WIDTH_16) ?
                      {{16{in_sample[15]}}, in_sample[15:0]} : in_sample;
  assign neg        = sample_ext[SAMPLE_W-1];

  // decide what stage two does
  always_comb begin
    item_next.neg    = neg;
    item_next.narrow = (cfg.sample_width == WIDTH_16);
    item_next.gain   = (gain_raw > GAIN_UNITY) ? GAIN_UNITY : gain_raw;
    item_next.op     = OP_PASS;
    item_next.value  = sample_ext;
    case (cfg.sample_width)
      WIDTH_RAW, WIDTH_RAW3: begin
        item_next.value = in_sample;
      end
      default: begin
        if (count != '0 && (entry & MAP_NO_ENTRY_BIT) == '0) begin
          if (cfg.mute_mask[entry[2:0]]) begin
            item_next.op = OP_ZERO;
          end else begin
            item_next.op    = OP_SCALE;
            item_next.value = neg ? (SAMPLE_W'(0) - sample_ext) : sample_ext;
          end
        end
      end
    endcase
  end

  // frame position and input register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      item_valid     <= 1'b0;
    end else begin
      if (accept) begin
        frame_position <= frame_position_next;
      end
      if (in_ready) begin
        item_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

  `PCGM_ASSERT_NEXT(a_pos_in_frame, clk, rst, accept && count != '0,
    {1'b0, frame_position} < $past(count), "frame position left the frame")
  `PCGM_ASSERT_NOW(a_gain_capped, clk, rst, item_valid && item.op == OP_SCALE,
    item.gain <= GAIN_UNITY, "gain above unity reached the multiplier")
  `PCGM_ASSERT_NOW(a_narrow_mag, clk, rst,
    item_valid && item.op == OP_SCALE && item.narrow,
    item.value <= SAMPLE_W'(32768), "16-bit magnitude out of range")

endmodule

`default_nettype wire

// ===== sv/pcgm_scale.sv =====
// ---------------------------------------------------------------------------
// pcgm_scale
// Gain multiply with truncation toward zero, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "per_channel_gain_mute_assert.svh"

module pcgm_scale (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire pcgm_pkg::pcgm_item_t item,
  output      logic                 take,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [31:0]          out_sample
);
  import pcgm_pkg::*;

  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] quot;
  logic [SAMPLE_W-1:0] scaled;
  logic [SAMPLE_W-1:0] result;

  // output register loads when empty or when its request is taken
  assign take = !out_valid || out_ready;

  // magnitude times gain, drop fraction bits, restore sign
  assign prod   = item.value * item.gain;
  assign quot   = prod[GAIN_FRAC_BITS +: SAMPLE_W];
  assign scaled = item.neg ? (SAMPLE_W'(0) - quot) : quot;

  always_comb begin
    case (item.op)
      OP_PASS:  result = item.value;
      OP_ZERO:  result = '0;
      OP_SCALE: result = item.narrow ? {{16{scaled[15]}}, scaled[15:0]} : scaled;
      default:  result = item.value;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_valid) begin
      out_sample <= result;
    end
  end

  `PCGM_ASSERT_NEXT(a_item_lands, clk, rst, item_valid && take, out_valid,
    "taken item did not reach the output register")
  `PCGM_ASSERT_NOW(a_out_source, clk, rst, $rose(out_valid), $past(item_valid),
    "output request without an item behind it")

endmodule

`default_nettype wire

// ===== sv/per_channel_gain_mute.sv =====
// ---------------------------------------------------------------------------
// per_channel_gain_mute
// Per-channel volume and mute for an interleaved audio sample stream.
// ---------------------------------------------------------------------------
// Takes one sample per clock unless the output stalls and returns one result
// per sample, in order. A sample passes the input register and then the output
// register; the one 32x16 multiply between them is combinational, so a new
// sample can be taken every clock the output is not stalled. The frame position
// advances as each sample is taken. The input register can take a new sample
// while a finished one waits on the master side, if it is empty. Configuration
// writes are always ready and should be made while no sample is in flight.
`default_nettype none

module per_channel_gain_mute (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // sample input
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] sample_in
  input  wire logic        s_axis_tuser,  // [0] buffer_start
  // sample output
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata   // [31:0] sample_out
);
  import pcgm_pkg::*;

  pcgm_cfg_t  cfg;
  pcgm_item_t item;
  logic       item_valid;
  logic       take;

  pcgm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcgm_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_sample  (s_axis_tdata),
    .in_start   (s_axis_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  pcgm_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== verif/gain_mute_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gain_mute_checker
// Watches the configuration, sample input and sample output channels of the
// per-channel gain and mute block. Keeps its own copy of the registers and
// of the frame position, works out the output for every accepted input
// request and compares each accepted output request with the oldest one.
// ---------------------------------------------------------------------------

module gain_mute_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          pending,
  output int          fail_count
);
  import pcgm_pkg::*;

  pcgm_cfg_t          shadow;
  logic [POS_W-1:0]   frame_pos;
  logic [31:0]        expected_samples[$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch: %s, sample_out %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] sext16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [COUNT_W-1:0] frame_len();
    return (shadow.channel_count > COUNT_MAX) ? COUNT_MAX : shadow.channel_count;
  endfunction

  // output for one sample at a given frame position
  function automatic logic [31:0] scaled_sample(input logic [31:0] raw,
                                                input logic [POS_W-1:0] pos);
    logic [3:0]  entry;
    logic [31:0] s;
    logic [31:0] mag;
    logic [31:0] q;
    logic [31:0] res;
    logic [15:0] gain;
    logic [63:0] word;
    logic [47:0] prod;
    if (shadow.sample_width == WIDTH_RAW || shadow.sample_width == WIDTH_RAW3)
      return raw;
    s = (shadow.sample_width == WIDTH_16) ? sext16(raw) : raw;
    res = s;
    entry = shadow.channel_map[pos*4 +: 4];
    // map codes 8 and up mean no gain entry
    if (frame_len() != 0 && !entry[3]) begin
      if (shadow.mute_mask[entry[2:0]]) begin
        res = '0;
      end else begin
        word = entry[2] ? shadow.gains_high : shadow.gains_low;
        gain = word[entry[1:0]*16 +: 16];
        if (gain > GAIN_UNITY)
          gain = GAIN_UNITY;
        // sign and magnitude so the product truncates toward zero
        mag = s[31] ? -s : s;
        prod = mag * gain;
        q = prod[GAIN_FRAC_BITS +: 32];
        res = s[31] ? -q : q;
      end
    end
    if (shadow.sample_width == WIDTH_16)
      res = sext16(res);
    return res;
  endfunction

  always @(posedge clk) begin : track
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] len;
    logic [31:0]        want;
    if (rst) begin
      shadow.gains_low     = GAINS_RESET;
      shadow.gains_high    = GAINS_RESET;
      shadow.mute_mask     = MUTE_RESET;
      shadow.channel_count = CHAN_COUNT_RESET;
      shadow.sample_width  = WIDTH_16;
      shadow.channel_map   = CHAN_MAP_RESET;
      frame_pos = '0;
      expected_samples.delete();
    end else begin
      // register writes; indexes past the map are dropped
      if (cfg_valid && cfg_ready) begin
        case (pcgm_reg_t'(cfg_index))
          REG_GAINS_LOW:     shadow.gains_low = cfg_data;
          REG_GAINS_HIGH:    shadow.gains_high = cfg_data;
          REG_MUTE_MASK:     shadow.mute_mask = cfg_data[7:0];
          REG_CHANNEL_COUNT: shadow.channel_count = cfg_data[COUNT_W-1:0];
          REG_SAMPLE_WIDTH:  shadow.sample_width = pcgm_width_t'(cfg_data[1:0]);
          REG_CHANNEL_MAP:   shadow.channel_map = cfg_data[31:0];
          default: ;
        endcase
      end
      // output side first, so a request taken this edge is never the one compared
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("output request with none outstanding", m_axis_tdata, '0);
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata !== want)
            report_mismatch("wrong sample_out", m_axis_tdata, want);
        end
      end
      // input side: predict, then step the frame position
      if (s_axis_tvalid && s_axis_tready) begin
        pos = s_axis_tuser ? '0 : frame_pos;
        expected_samples.push_back(scaled_sample(s_axis_tdata, pos));
        len = frame_len();
        // start flag clears the position even when the count is zero
        frame_pos = pos;
        if (len != 0)
          frame_pos = ({1'b0, pos} + 4'd1 >= len) ? '0 : pos + 3'd1;
      end
    end
    pending <= expected_samples.size();
  end

endmodule

// ===== verif/per_channel_gain_mute_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_channel_gain_mute_tb
// Drives configuration writes and sample streams into the gain and mute
// block under several idle and stall mixes, with a short directed section
// followed by random buffers; the checker beside the block does the scoring.
// ---------------------------------------------------------------------------

module per_channel_gain_mute_tb;
  import pcgm_pkg::*;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          DRAIN_CYCLES  = 4;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_ITEMS   = 125;
  localparam logic [2:0]  REG_SPARE_A   = 3'd6;
  localparam logic [2:0]  REG_SPARE_B   = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  int          pending;
  int          fail_count;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  always #4 clk = ~clk;

  per_channel_gain_mute dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),   // [31:0] sample_in
    .s_axis_tuser  (s_user),   // [0] buffer_start
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)    // [31:0] sample_out
  );

  gain_mute_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  // output side back-pressure
  always @(posedge clk)
    m_ready <= ($urandom_range(0, 99) >= stall_pct);

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stop sending and wait until every outstanding request has come out
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one sample request; valid stays high afterward unless a gap follows
  task automatic send_sample(input logic [31:0] data, input logic start,
                             input logic hold_off);
    if (hold_off) begin
      s_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0)
        @(posedge clk);
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= data;
    s_user  <= start;
    do @(posedge clk); while (!s_ready);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return GAIN_UNITY;
      2:       return 16'hFFFF;
      5:       return 16'($urandom);
      default: return 16'($urandom_range(0, GAIN_UNITY));
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      4: return {{16{r[15]}}, r[15:0]};
      5: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h0000_8000;
          default: return 32'h0000_7FFF;
        endcase
      end
      6:       return 32'($urandom_range(0, 15));
      7:       return -32'($urandom_range(0, 15));
      default: return r;
    endcase
  endfunction

  // phase 0 sets every register bit, phase 1 clears them, later ones are random
  task automatic write_phase_config(input int phase);
    logic [63:0] gl;
    logic [63:0] gh;
    logic [31:0] cmap;
    logic [3:0]  cnt;
    logic [1:0]  wid;
    logic [7:0]  mute;
    for (int i = 0; i < 4; i++) begin
      gl[i*16 +: 16] = pick_gain();
      gh[i*16 +: 16] = pick_gain();
    end
    for (int p = 0; p < 8; p++)
      cmap[p*4 +: 4] = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 7))
                                                  : 4'($urandom_range(8, 15));
    cnt = ($urandom_range(0, 7) != 0) ? 4'($urandom_range(1, 8)) : 4'($urandom);
    case ($urandom_range(0, 9))
      8:       wid = WIDTH_RAW;
      9:       wid = WIDTH_RAW3;
      default: wid = ($urandom_range(0, 1) != 0) ? WIDTH_32 : WIDTH_16;
    endcase
    mute = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom & $urandom);
    if (phase == 0) begin
      gl = '1; gh = '1; cmap = '1; cnt = '1; wid = WIDTH_RAW3; mute = '1;
    end else if (phase == 1) begin
      gl = '0; gh = '0; cmap = '0; cnt = '0; wid = WIDTH_16; mute = '0;
    end
    write_reg(REG_GAINS_LOW, gl);
    write_reg(REG_GAINS_HIGH, gh);
    write_reg(REG_MUTE_MASK, {$urandom, 24'h0, mute});
    write_reg(REG_CHANNEL_COUNT, 64'(cnt));
    write_reg(REG_SAMPLE_WIDTH, 64'(wid));
    write_reg(REG_CHANNEL_MAP, {$urandom, cmap});
    if ($urandom_range(0, 1) != 0)
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                {$urandom, $urandom});
  endtask

  initial begin
    int left;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 16-bit stereo at unity, upper bits of the word ignored
    send_sample(32'h0000_7FFF, 1'b1, 1'b0);
    send_sample(32'hFFFF_8000, 1'b0, 1'b0);
    send_sample(32'h1234_8000, 1'b0, 1'b0);

    // 32-bit, eight channels, mixed gains, one muted entry, unmapped tail
    wait_drained();
    write_reg(REG_GAINS_LOW, 64'hFFFF_8001_0000_4000);
    write_reg(REG_GAINS_HIGH, 64'h0001_7FFF_8000_2000);
    write_reg(REG_MUTE_MASK, 64'h20);
    write_reg(REG_CHANNEL_COUNT, 64'd8);
    write_reg(REG_SAMPLE_WIDTH, 64'(WIDTH_32));
    write_reg(REG_CHANNEL_MAP, 64'hF954_3210);
    write_reg(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SPARE_B, 64'h0);
    send_sample(32'h8000_0000, 1'b1, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h8000_0001, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b0, 1'b0);
    send_sample(32'h1234_5678, 1'b0, 1'b0);
    send_sample(32'hDEAD_BEEF, 1'b0, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);

    // count above the channel limit with an unsupported width
    wait_drained();
    write_reg(REG_CHANNEL_COUNT, 64'd12);
    write_reg(REG_SAMPLE_WIDTH, 64'(WIDTH_RAW));
    send_sample(32'h8765_4321, 1'b0, 1'b0);
    send_sample(32'h0000_FFFF, 1'b1, 1'b0);
    send_sample(32'hFFFF_0000, 1'b0, 1'b0);

    // zero channel count in 16-bit mode, start flag still clears position
    wait_drained();
    write_reg(REG_CHANNEL_COUNT, 64'd0);
    write_reg(REG_SAMPLE_WIDTH, 64'(WIDTH_16));
    send_sample(32'hABCD_9876, 1'b0, 1'b0);
    send_sample(32'h0001_7FFF, 1'b1, 1'b0);
    send_sample(32'h0000_8000, 1'b0, 1'b0);

    // position left beyond a count lowered mid-frame
    wait_drained();
    write_reg(REG_CHANNEL_COUNT, 64'd8);
    write_reg(REG_SAMPLE_WIDTH, 64'(WIDTH_32));
    for (int i = 0; i < 5; i++)
      send_sample(pick_sample(), (i == 0), 1'b0);
    wait_drained();
    write_reg(REG_CHANNEL_COUNT, 64'd3);
    for (int i = 0; i < 3; i++)
      send_sample(pick_sample(), 1'b0, 1'b0);

    // random buffers under each idle and stall mix
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      write_phase_config(phase);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (left == 0)
          left = $urandom_range(1, 64);
        send_sample(pick_sample(),
                    (left == 1 && n != 0) || n == 0 || ($urandom_range(0, 19) == 0),
                    (phase == 2 && n == 10) || ($urandom_range(0, 149) == 0));
        left--;
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
